@@ src/leb_pkg.sv @@
`timescale 1ns / 1ps

package leb_pkg;

    localparam int MAX_LEN_DEF = 32;
    localparam int CHAR_W      = 8;
    localparam int CMD_W       = 3;

    localparam logic [CHAR_W-1:0] KEY_LOW  = 8'h20;
    localparam logic [CHAR_W-1:0] KEY_HIGH = 8'h7E;

    typedef enum logic [CMD_W-1:0] {
        CMD_HOME  = 3'd0,
        CMD_END   = 3'd1,
        CMD_LEFT  = 3'd2,
        CMD_RIGHT = 3'd3,
        CMD_TYPE  = 3'd4,
        CMD_ERASE = 3'd5,
        CMD_PRINT = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_OK,
        EMIT_REJECT,
        EMIT_SEP,
        EMIT_CHAR
    } emit_t;

    typedef enum logic {
        RD_IDX,
        RD_IDX_M1
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_UP,
        WR_KEY,
        WR_DOWN
    } wr_sel_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_LOAD_LEN,
        IDX_LOAD_CUR,
        IDX_CLEAR,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef struct packed {
        logic    latch;
        logic    exec_simple;
        idx_op_t idx_op;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    commit_ins;
        logic    commit_era;
        emit_t   emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             key_ok;
        logic             full;
        logic             cur_zero;
        logic             idx_gt_cur;
        logic             idx_lt_len;
        logic             sep_hit;
        logic             len_zero;
    } dp_stat_t;

endpackage

@@ src/leb_ram.sv @@
`timescale 1ns / 1ps

module leb_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/leb_ctrl.sv @@
`timescale 1ns / 1ps

module leb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  leb_pkg::dp_stat_t   stat,
    output logic                busy,
    output leb_pkg::ctrl_cmd_t  ctrl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_RD,
        S_INS_WR,
        S_ERA_RD,
        S_ERA_WR,
        S_PR_SEP,
        S_PR_RD,
        S_PR_CH
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    always_comb
    begin
        state_next       = state_reg;
        ctrl.latch       = 1'b0;
        ctrl.exec_simple = 1'b0;
        ctrl.idx_op      = leb_pkg::IDX_HOLD;
        ctrl.rd_sel      = leb_pkg::RD_IDX;
        ctrl.wr_en       = 1'b0;
        ctrl.wr_sel      = leb_pkg::WR_UP;
        ctrl.commit_ins  = 1'b0;
        ctrl.commit_era  = 1'b0;
        ctrl.emit        = leb_pkg::EMIT_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.latch = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                case (stat.cmd)
                    leb_pkg::CMD_HOME, leb_pkg::CMD_END,
                    leb_pkg::CMD_LEFT, leb_pkg::CMD_RIGHT:
                    begin
                        ctrl.exec_simple = 1'b1;
                        ctrl.emit        = leb_pkg::EMIT_OK;
                    end
                    leb_pkg::CMD_TYPE:
                    begin
                        if (!stat.key_ok || stat.full)
                        begin
                            ctrl.emit = leb_pkg::EMIT_REJECT;
                        end
                        else
                        begin
                            ctrl.idx_op = leb_pkg::IDX_LOAD_LEN;
                            state_next  = S_INS_RD;
                        end
                    end
                    leb_pkg::CMD_ERASE:
                    begin
                        if (stat.cur_zero)
                        begin
                            ctrl.emit = leb_pkg::EMIT_REJECT;
                        end
                        else
                        begin
                            ctrl.idx_op = leb_pkg::IDX_LOAD_CUR;
                            state_next  = S_ERA_RD;
                        end
                    end
                    leb_pkg::CMD_PRINT:
                    begin
                        ctrl.idx_op = leb_pkg::IDX_CLEAR;
                        state_next  = S_PR_SEP;
                    end
                    default:
                    begin
                        ctrl.emit = leb_pkg::EMIT_REJECT;
                    end
                endcase
            end
            S_INS_RD:
            begin
                if (stat.idx_gt_cur)
                begin
                    ctrl.rd_sel = leb_pkg::RD_IDX_M1;
                    state_next  = S_INS_WR;
                end
                else
                begin
                    ctrl.wr_en      = 1'b1;
                    ctrl.wr_sel     = leb_pkg::WR_KEY;
                    ctrl.commit_ins = 1'b1;
                    ctrl.emit       = leb_pkg::EMIT_OK;
                    state_next      = S_IDLE;
                end
            end
            S_INS_WR:
            begin
                ctrl.wr_en  = 1'b1;
                ctrl.wr_sel = leb_pkg::WR_UP;
                ctrl.idx_op = leb_pkg::IDX_DEC;
                state_next  = S_INS_RD;
            end
            S_ERA_RD:
            begin
                if (stat.idx_lt_len)
                begin
                    ctrl.rd_sel = leb_pkg::RD_IDX;
                    state_next  = S_ERA_WR;
                end
                else
                begin
                    ctrl.commit_era = 1'b1;
                    ctrl.emit       = leb_pkg::EMIT_OK;
                    state_next      = S_IDLE;
                end
            end
            S_ERA_WR:
            begin
                ctrl.wr_en  = 1'b1;
                ctrl.wr_sel = leb_pkg::WR_DOWN;
                ctrl.idx_op = leb_pkg::IDX_INC;
                state_next  = S_ERA_RD;
            end
            S_PR_SEP:
            begin
                if (stat.sep_hit)
                begin
                    ctrl.emit = leb_pkg::EMIT_SEP;
                end
                if (stat.idx_lt_len)
                begin
                    state_next = S_PR_RD;
                end
                else
                begin
                    if (!stat.sep_hit && stat.len_zero)
                    begin
                        ctrl.emit = leb_pkg::EMIT_OK;
                    end
                    state_next = S_IDLE;
                end
            end
            S_PR_RD:
            begin
                ctrl.rd_sel = leb_pkg::RD_IDX;
                state_next  = S_PR_CH;
            end
            S_PR_CH:
            begin
                ctrl.emit   = leb_pkg::EMIT_CHAR;
                ctrl.idx_op = leb_pkg::IDX_INC;
                state_next  = S_PR_SEP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

@@ src/leb_dp.sv @@
`timescale 1ns / 1ps

module leb_dp #(
    parameter int MAX_LEN = leb_pkg::MAX_LEN_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [leb_pkg::CMD_W-1:0]  command,
    input  logic [leb_pkg::CHAR_W-1:0] key,
    input  logic [leb_pkg::CHAR_W-1:0] separator,
    input  leb_pkg::ctrl_cmd_t         ctrl,
    output leb_pkg::dp_stat_t          stat,
    output logic                       result_valid,
    output logic                       status,
    output logic [leb_pkg::CHAR_W-1:0] out_char,
    output logic                       char_valid,
    output logic                       last
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [leb_pkg::CMD_W-1:0]  cmd_reg;
    logic [leb_pkg::CHAR_W-1:0] key_reg;
    logic [leb_pkg::CHAR_W-1:0] sep_reg;
    logic [LW-1:0]              len_reg, len_next;
    logic [LW-1:0]              cur_reg, cur_next;
    logic [LW-1:0]              idx_reg, idx_next;
    logic                       result_valid_reg, result_valid_next;
    logic                       status_reg, status_next;
    logic [leb_pkg::CHAR_W-1:0] out_char_reg, out_char_next;
    logic                       char_valid_reg, char_valid_next;
    logic                       last_reg, last_next;

    logic [LW-1:0]              idx_m1;
    logic [LW-1:0]              idx_p1;
    logic                       sep_nz;
    logic                       sep_at_end;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [AW-1:0]              ram_raddr;
    logic [leb_pkg::CHAR_W-1:0] ram_wdata;
    logic [leb_pkg::CHAR_W-1:0] ram_rdata;

    assign idx_m1     = idx_reg - LW'(1);
    assign idx_p1     = idx_reg + LW'(1);
    assign sep_nz     = (sep_reg != '0);
    assign sep_at_end = (cur_reg == len_reg) && sep_nz;

    assign stat.cmd        = cmd_reg;
    assign stat.key_ok     = (key_reg >= leb_pkg::KEY_LOW) && (key_reg <= leb_pkg::KEY_HIGH);
    assign stat.full       = (len_reg == LW'(MAX_LEN));
    assign stat.cur_zero   = (cur_reg == '0);
    assign stat.idx_gt_cur = (idx_reg > cur_reg);
    assign stat.idx_lt_len = (idx_reg < len_reg);
    assign stat.sep_hit    = (idx_reg == cur_reg) && sep_nz;
    assign stat.len_zero   = (len_reg == '0);

    always_comb
    begin
        ram_raddr = (ctrl.rd_sel == leb_pkg::RD_IDX_M1) ? idx_m1[AW-1:0] : idx_reg[AW-1:0];
        ram_we    = ctrl.wr_en;
        ram_wdata = ram_rdata;
        case (ctrl.wr_sel)
            leb_pkg::WR_UP:
            begin
                ram_waddr = idx_reg[AW-1:0];
            end
            leb_pkg::WR_KEY:
            begin
                ram_waddr = cur_reg[AW-1:0];
                ram_wdata = key_reg;
            end
            leb_pkg::WR_DOWN:
            begin
                ram_waddr = idx_m1[AW-1:0];
            end
            default:
            begin
                ram_waddr = idx_reg[AW-1:0];
            end
        endcase
    end

    leb_ram #(
        .WIDTH (leb_pkg::CHAR_W),
        .DEPTH (MAX_LEN)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        len_next = len_reg;
        cur_next = cur_reg;
        if (ctrl.exec_simple)
        begin
            case (cmd_reg)
                leb_pkg::CMD_HOME:
                begin
                    cur_next = '0;
                end
                leb_pkg::CMD_END:
                begin
                    cur_next = len_reg;
                end
                leb_pkg::CMD_LEFT:
                begin
                    if (cur_reg != '0)
                    begin
                        cur_next = cur_reg - LW'(1);
                    end
                end
                leb_pkg::CMD_RIGHT:
                begin
                    if (cur_reg < len_reg)
                    begin
                        cur_next = cur_reg + LW'(1);
                    end
                end
                default:
                begin
                    cur_next = cur_reg;
                end
            endcase
        end
        if (ctrl.commit_ins)
        begin
            len_next = len_reg + LW'(1);
            cur_next = cur_reg + LW'(1);
        end
        if (ctrl.commit_era)
        begin
            len_next = len_reg - LW'(1);
            cur_next = cur_reg - LW'(1);
        end
    end

    always_comb
    begin
        case (ctrl.idx_op)
            leb_pkg::IDX_LOAD_LEN: idx_next = len_reg;
            leb_pkg::IDX_LOAD_CUR: idx_next = cur_reg;
            leb_pkg::IDX_CLEAR:    idx_next = '0;
            leb_pkg::IDX_INC:      idx_next = idx_p1;
            leb_pkg::IDX_DEC:      idx_next = idx_m1;
            default:               idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        result_valid_next = 1'b1;
        status_next       = 1'b0;
        out_char_next     = '0;
        char_valid_next   = 1'b0;
        last_next         = 1'b1;
        case (ctrl.emit)
            leb_pkg::EMIT_OK:
            begin
                status_next = 1'b0;
            end
            leb_pkg::EMIT_REJECT:
            begin
                status_next = 1'b1;
            end
            leb_pkg::EMIT_SEP:
            begin
                out_char_next   = sep_reg;
                char_valid_next = 1'b1;
                last_next       = (idx_reg == len_reg);
            end
            leb_pkg::EMIT_CHAR:
            begin
                out_char_next   = ram_rdata;
                char_valid_next = 1'b1;
                last_next       = (idx_p1 == len_reg) && !sep_at_end;
            end
            default:
            begin
                result_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg          <= '0;
            cur_reg          <= '0;
            idx_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg          <= len_next;
            cur_reg          <= cur_next;
            idx_reg          <= idx_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
        begin
            cmd_reg <= command;
            key_reg <= key;
            sep_reg <= separator;
        end
        status_reg     <= status_next;
        out_char_reg   <= out_char_next;
        char_valid_reg <= char_valid_next;
        last_reg       <= last_next;
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign out_char     = out_char_reg;
    assign char_valid   = char_valid_reg;
    assign last         = last_reg;

endmodule

@@ src/line_edit_buffer_with_cursor.sv @@
`timescale 1ns / 1ps
// Home, end, left, right and rejected commands: result in the cycle after decode, and a
// new command is taken once busy falls. Type and erase stay busy for the read-then-write
// shift through the single-port-per-direction line store.
// Print: up to len + 1 results, each a one-cycle strobe.
// Reset clears length and cursor at once; the line store is not cleared.
// Results cannot be stalled by the receiver.

module line_edit_buffer_with_cursor #(
    parameter int MAX_LEN = leb_pkg::MAX_LEN_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [leb_pkg::CMD_W-1:0]  command,
    input  logic [leb_pkg::CHAR_W-1:0] key,
    input  logic [leb_pkg::CHAR_W-1:0] separator,
    output logic                       result_valid,
    output logic                       status,
    output logic [leb_pkg::CHAR_W-1:0] out_char,
    output logic                       char_valid,
    output logic                       last
);

    leb_pkg::ctrl_cmd_t ctrl;
    leb_pkg::dp_stat_t  stat;

    leb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    leb_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .command      (command),
        .key          (key),
        .separator    (separator),
        .ctrl         (ctrl),
        .stat         (stat),
        .result_valid (result_valid),
        .status       (status),
        .out_char     (out_char),
        .char_valid   (char_valid),
        .last         (last)
    );

endmodule

@@ src/leb_checker.sv @@
`timescale 1ns / 1ps

module leb_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic result_valid,
    input logic status,
    input logic char_valid,
    input logic last
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a transfer in");

    a_result_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without a command in progress");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> !result_valid)
        else $error("result while idle");

    a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status || !char_valid)) |-> last)
        else $error("status-only result not marked last");

endmodule

bind line_edit_buffer_with_cursor leb_checker u_leb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .status       (status),
    .char_valid   (char_valid),
    .last         (last)
);

@@ bench/tb_line_edit_buffer_with_cursor.sv @@
`timescale 1ns / 1ps

module tb_line_edit_buffer_with_cursor;

    localparam int CHAR_W        = leb_pkg::CHAR_W;
    localparam int CMD_W         = leb_pkg::CMD_W;
    localparam int LINE_MAX      = leb_pkg::MAX_LEN_DEF;
    localparam int RANDOM_ITEMS  = 50;
    localparam int DRAIN_CYCLES  = 3 * LINE_MAX + 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PRINT_CAP     = 40;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    typedef struct {
        bit             status;
        bit [CHAR_W-1:0] ch;
        bit             valid;
        bit             last;
    } line_result_t;

    class line_scoreboard;
        bit [CHAR_W-1:0] text[LINE_MAX];
        int              len;
        int              cur;
        line_result_t    pending[$];
        int              errors;
        int              checked;
        int              commands;
        int              prints;
        int              rejects;
        int              full_hits;
        int              longest;

        function new();
            len = 0;
            cur = 0;
            errors = 0;
            checked = 0;
            commands = 0;
            prints = 0;
            rejects = 0;
            full_hits = 0;
            longest = 0;
        endfunction

        function void push_result(bit st, bit [CHAR_W-1:0] ch, bit vld, bit lst);
            line_result_t r;
            r.status = st;
            r.ch     = ch;
            r.valid  = vld;
            r.last   = lst;
            pending.push_back(r);
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] k,
                                   logic [CHAR_W-1:0] sep);
            bit st;
            int n;
            st = 1'b0;
            n = 0;
            commands++;
            case (cmd)
                leb_pkg::CMD_HOME:  cur = 0;
                leb_pkg::CMD_END:   cur = len;
                leb_pkg::CMD_LEFT:  if (cur > 0) cur--;
                leb_pkg::CMD_RIGHT: if (cur < len) cur++;
                leb_pkg::CMD_TYPE:
                begin
                    if (k < leb_pkg::KEY_LOW || k > leb_pkg::KEY_HIGH) begin
                        st = 1'b1;
                    end else if (len >= LINE_MAX) begin
                        st = 1'b1;
                        full_hits++;
                    end else begin
                        for (int i = len; i > cur; i--) text[i] = text[i-1];
                        text[cur] = k;
                        len++;
                        cur++;
                        if (len > longest) longest = len;
                    end
                end
                leb_pkg::CMD_ERASE:
                begin
                    if (cur == 0) begin
                        st = 1'b1;
                    end else begin
                        for (int i = cur; i < len; i++) text[i-1] = text[i];
                        len--;
                        cur--;
                    end
                end
                leb_pkg::CMD_PRINT:
                begin
                    prints++;
                    for (int i = 0; i <= len; i++) begin
                        if (i == cur && sep != 0) begin
                            push_result(1'b0, sep, 1'b1, 1'b0);
                            n++;
                        end
                        if (i < len) begin
                            push_result(1'b0, text[i], 1'b1, 1'b0);
                            n++;
                        end
                    end
                    if (n == 0) push_result(1'b0, '0, 1'b0, 1'b1);
                    else pending[pending.size()-1].last = 1'b1;
                    return;
                end
                default:   st = 1'b1;
            endcase
            if (st) rejects++;
            push_result(st, '0, 1'b0, 1'b1);
        endfunction

        task report_mismatch(string msg);
            if (errors < PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(bit st, bit [CHAR_W-1:0] ch, bit vld, bit lst);
            line_result_t r;
            checked++;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result st=%0b ch=%02h v=%0b l=%0b",
                                          st, ch, vld, lst));
                return;
            end
            r = pending.pop_front();
            if (r.status !== st || r.ch !== ch || r.valid !== vld || r.last !== lst)
                report_mismatch($sformatf({"got st=%0b ch=%02h v=%0b l=%0b, ",
                                           "want st=%0b ch=%02h v=%0b l=%0b"},
                                          st, ch, vld, lst,
                                          r.status, r.ch, r.valid, r.last));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [CMD_W-1:0]   command;
    logic [CHAR_W-1:0]  key;
    logic [CHAR_W-1:0]  separator;
    logic               result_valid;
    logic               status;
    logic [CHAR_W-1:0]  out_char;
    logic               char_valid;
    logic               last;

    line_scoreboard sb;
    bit             steady;
    int             cycle_count;

    line_edit_buffer_with_cursor uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .key          (key),
        .separator    (separator),
        .result_valid (result_valid),
        .status       (status),
        .out_char     (out_char),
        .char_valid   (char_valid),
        .last         (last)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid) sb.check_result(status, out_char, char_valid, last);
    end

    // Entered and left at a falling edge.
    task send_command(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] k, logic [CHAR_W-1:0] sep);
        while (!steady && $urandom_range(99) < 37) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start     <= 1'b1;
        command   <= cmd;
        key       <= k;
        separator <= sep;
        do @(posedge clk); while (busy);
        sb.note_command(cmd, k, sep);
        @(negedge clk);
    endtask

    function logic [CHAR_W-1:0] pick_key();
        if ($urandom_range(9) == 0) return CHAR_W'($urandom_range(255));
        return CHAR_W'($urandom_range(leb_pkg::KEY_HIGH, leb_pkg::KEY_LOW));
    endfunction

    function logic [CHAR_W-1:0] pick_sep();
        int roll;
        roll = $urandom_range(9);
        if (roll < 3) return '0;
        if (roll < 5) return CHAR_W'($urandom_range(255));
        return CHAR_W'($urandom_range(leb_pkg::KEY_HIGH, leb_pkg::KEY_LOW));
    endfunction

    task random_command();
        int roll;
        roll = $urandom_range(99);
        if (roll < 32)      send_command(leb_pkg::CMD_TYPE, pick_key(), pick_sep());
        else if (roll < 50) send_command(leb_pkg::CMD_ERASE, pick_key(), pick_sep());
        else if (roll < 60) send_command(leb_pkg::CMD_LEFT, pick_key(), pick_sep());
        else if (roll < 70) send_command(leb_pkg::CMD_RIGHT, pick_key(), pick_sep());
        else if (roll < 75) send_command(leb_pkg::CMD_HOME, pick_key(), pick_sep());
        else if (roll < 80) send_command(leb_pkg::CMD_END, pick_key(), pick_sep());
        else if (roll < 97) send_command(leb_pkg::CMD_PRINT, pick_key(), pick_sep());
        else                send_command(CMD_UNUSED, pick_key(), pick_sep());
    endtask

    initial
    begin
        sb          = new();
        steady      = 1'b0;
        cycle_count = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        command     = leb_pkg::CMD_HOME;
        key         = '0;
        separator   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_command(leb_pkg::CMD_PRINT, 8'h00, 8'h00);
        send_command(leb_pkg::CMD_PRINT, 8'h00, 8'hFF);
        send_command(leb_pkg::CMD_ERASE, 8'h41, 8'h00);
        send_command(leb_pkg::CMD_LEFT,  8'h00, 8'h00);
        send_command(leb_pkg::CMD_RIGHT, 8'h00, 8'h00);
        send_command(leb_pkg::CMD_TYPE,  8'h00, 8'h00);
        send_command(leb_pkg::CMD_TYPE,  8'hFF, 8'hFF);
        send_command(leb_pkg::CMD_TYPE,  8'h1F, 8'h00);
        send_command(leb_pkg::CMD_TYPE,  8'h7F, 8'h00);
        send_command(leb_pkg::CMD_TYPE,  8'h20, 8'h00);
        send_command(leb_pkg::CMD_TYPE,  8'h7E, 8'h00);
        send_command(leb_pkg::CMD_TYPE,  8'h41, 8'h00);
        send_command(leb_pkg::CMD_RIGHT, 8'h00, 8'h00);
        send_command(leb_pkg::CMD_HOME,  8'h00, 8'h00);
        send_command(leb_pkg::CMD_LEFT,  8'h00, 8'h00);
        send_command(leb_pkg::CMD_TYPE,  8'h55, 8'h00);
        send_command(leb_pkg::CMD_RIGHT, 8'h00, 8'h00);
        send_command(leb_pkg::CMD_PRINT, 8'h00, 8'h7C);
        send_command(leb_pkg::CMD_END,   8'h00, 8'h00);
        send_command(leb_pkg::CMD_ERASE, 8'h00, 8'h00);
        send_command(leb_pkg::CMD_LEFT,  8'h00, 8'h00);
        send_command(leb_pkg::CMD_ERASE, 8'h00, 8'h00);
        send_command(leb_pkg::CMD_PRINT, 8'h00, 8'h00);
        send_command(CMD_UNUSED, 8'hAA, 8'h55);
        send_command(leb_pkg::CMD_PRINT, 8'hFF, 8'h80);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 28 && n < 46);
            if (n == 20) begin
                // fill the line from a random cursor, then hit the full limit
                while (sb.len < LINE_MAX)
                    send_command(leb_pkg::CMD_TYPE,
                                 CHAR_W'($urandom_range(leb_pkg::KEY_HIGH, leb_pkg::KEY_LOW)),
                                 pick_sep());
                send_command(leb_pkg::CMD_TYPE,
                             CHAR_W'($urandom_range(leb_pkg::KEY_HIGH, leb_pkg::KEY_LOW)),
                             8'h00);
                send_command(leb_pkg::CMD_TYPE, leb_pkg::KEY_LOW, 8'h00);
                send_command(leb_pkg::CMD_PRINT, 8'h00, 8'h23);
                send_command(leb_pkg::CMD_HOME, 8'h00, 8'h00);
                send_command(leb_pkg::CMD_PRINT, 8'h00, 8'h00);
                send_command(leb_pkg::CMD_END, 8'h00, 8'h00);
                send_command(leb_pkg::CMD_PRINT, 8'h00, 8'hFF);
            end
            random_command();
        end
        start <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d commands: %0d prints, %0d rejected, %0d full-line rejects",
                 sb.commands, sb.prints, sb.rejects, sb.full_hits);
        $display("Checked %0d result transfers, longest line %0d of %0d, %0d mismatches",
                 sb.checked, sb.longest, LINE_MAX, sb.errors);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
src/leb_pkg.sv
src/leb_ram.sv
src/leb_ctrl.sv
src/leb_dp.sv
src/line_edit_buffer_with_cursor.sv
src/leb_checker.sv
bench/tb_line_edit_buffer_with_cursor.sv
